### hdl/sial_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sial_pkg - switch input activation latch package
// Shared sizes, codes and transaction payload types.
// ----------------------------------------------------------------------------
package sial_pkg;

    localparam int PORTS     = 8;
    localparam int CHANNELS  = 2;
    localparam int TIME_BITS = 32;

    localparam int PORT_BITS = $clog2(PORTS);
    localparam int IDX_BITS  = $clog2(PORTS * CHANNELS);
    localparam int CFG_BITS  = 32;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd100;

    // item function codes
    localparam logic [1:0] FUNC_EDGE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // channel modes
    localparam logic [1:0] MODE_TOGGLE_UP   = 2'd0;
    localparam logic [1:0] MODE_TOGGLE_DOWN = 2'd1;
    localparam logic [1:0] MODE_MOM_UP      = 2'd2;
    localparam logic [1:0] MODE_MOM_DOWN    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PORT_COUNT = 2'd0;
    localparam logic [1:0] CFG_MODES      = 2'd1;
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] port;
        logic       channel;
        logic       edge_rising;
    } req_t;

    typedef struct packed {
        logic [1:0] activations;
        logic       accepted;
        logic       attention;
        logic       port_valid;
    } rsp_t;

endpackage

### hdl/switch_input_activation_latch_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_input_activation_latch_core - debounced switch edge latch
// Latches debounced switch activations per port and channel, keeps a
// millisecond time base and returns/clears a port's bits on read.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   sial_pkg::req_t
//  rsp       out        rsp_valid/rsp_stall   sial_pkg::rsp_t
//  cfg       in         cfg_we                cfg_index, cfg_data
//
//  One transaction per cycle sustained while the response is not stalled; each
//  request gives one response, via the request register, then the response register.
//  The state read-modify-write of one item is done in the cycle it leaves
//  the request register. Reset clears all state but the request and response payloads and sets debounce to 100.
//  A stalled response holds the request register; a new request is still
//  taken whenever the request register can move on.
// ----------------------------------------------------------------------------
module switch_input_activation_latch_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sial_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sial_pkg::rsp_t                rsp,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [sial_pkg::CFG_BITS-1:0] cfg_data
);
    import sial_pkg::*;

    logic [2:0]           port_count_reg;
    logic [31:0]          modes_reg;
    logic [15:0]          debounce_reg;

    logic [TIME_BITS-1:0] ms_reg, ms_next;
    logic [TIME_BITS-1:0] last_time_reg [PORTS*CHANNELS];
    logic [CHANNELS-1:0]  pending_reg [PORTS];
    logic [CHANNELS-1:0]  pending_next [PORTS];

    logic                 s1_valid_reg;
    req_t                 s1_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic                 s1_go;
    logic                 port_valid;
    logic [IDX_BITS-1:0]  idx;
    logic [1:0]           mode;
    logic                 counts;
    logic [TIME_BITS-1:0] delta;
    logic                 suppress;
    logic                 edge_hit;
    logic                 acc;
    logic                 rd_hit;
    logic [1:0]           acts;
    logic                 attention;

    assign s1_go     = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_count_reg <= '0;
            modes_reg      <= '0;
            debounce_reg   <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PORT_COUNT: port_count_reg <= cfg_data[2:0];
                CFG_MODES:      modes_reg      <= cfg_data[31:0];
                CFG_DEBOUNCE:   debounce_reg   <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // item evaluation
    assign port_valid = s1_reg.port < port_count_reg;
    // channel index = port * CHANNELS + channel
    assign idx        = {s1_reg.port, s1_reg.channel};
    assign mode       = modes_reg[{idx, 1'b0} +: 2];
    assign counts     = (mode == MODE_TOGGLE_UP) || (mode == MODE_TOGGLE_DOWN) ||
                        (mode == MODE_MOM_UP && !s1_reg.edge_rising) ||
                        (mode == MODE_MOM_DOWN && s1_reg.edge_rising);
    assign delta      = ms_reg - last_time_reg[idx];
    assign suppress   = (delta != '0) &&
                        (delta < {{(TIME_BITS-16){1'b0}}, debounce_reg});

    always_comb
    begin
        edge_hit = 1'b0;
        rd_hit   = 1'b0;
        ms_next  = ms_reg;
        unique case (s1_reg.func)
            FUNC_EDGE: edge_hit = port_valid && counts;
            FUNC_TICK: ms_next  = ms_reg + {{(TIME_BITS-1){1'b0}}, 1'b1};
            FUNC_READ: rd_hit   = port_valid;
            default:   ;
        endcase
    end

    assign acc  = edge_hit && !suppress;
    assign acts = rd_hit ? pending_reg[s1_reg.port] : '0;

    always_comb
    begin
        for (int p = 0; p < PORTS; p++)
        begin
            pending_next[p] = pending_reg[p];
        end
        if (acc)
        begin
            pending_next[s1_reg.port][s1_reg.channel] = 1'b1;
        end
        if (rd_hit)
        begin
            pending_next[s1_reg.port] = '0;
        end
    end

    always_comb
    begin
        attention = 1'b0;
        for (int p = 0; p < PORTS; p++)
        begin
            attention = attention | (|pending_next[p]);
        end
    end

    // state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg <= '0;
            for (int i = 0; i < PORTS*CHANNELS; i++)
            begin
                last_time_reg[i] <= '0;
            end
            for (int p = 0; p < PORTS; p++)
            begin
                pending_reg[p] <= '0;
            end
        end
        else if (s1_go)
        begin
            ms_reg <= ms_next;
            // suppressed edges restart the window too
            if (edge_hit)
            begin
                last_time_reg[idx] <= ms_reg;
            end
            for (int p = 0; p < PORTS; p++)
            begin
                pending_reg[p] <= pending_next[p];
            end
        end
    end

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            s1_reg <= req;
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            rsp_reg.activations <= acts;
            rsp_reg.accepted    <= acc;
            rsp_reg.attention   <= attention;
            rsp_reg.port_valid  <= port_valid;
        end
    end

    // checks
    a_acc_attention: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.accepted |-> rsp.attention && rsp.port_valid)
        else $error("accepted edge without attention or valid port");

    a_acts_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.activations != 2'b00) |-> rsp.port_valid && !rsp.accepted)
        else $error("activations reported on invalid port or edge item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && rsp_valid_reg)
        else $error("request stalled with free pipeline");

    a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_go |=> $stable(ms_reg))
        else $error("time base moved without an item");

endmodule
